// ===== sv/pspc_pkg.sv =====
// pspc_pkg: payload types, register indexes and reset values for the
// piecewise speed profile core. No dependencies.
package pspc_pkg;

    typedef struct packed {
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic        [15:0] range_len;
        logic               fast_point;
        logic               aim_locked;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } command_t;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DIST_W    = 16;
    localparam int unsigned SPEED_W   = 15;
    localparam int unsigned PROD_W    = 31;

    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_NORMAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_FAST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_ZONE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_FAST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_NORMAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FAR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_NEAR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FINE    = 3'd7;

    localparam logic [DIST_W-1:0]  RST_SWITCH_NORMAL = 16'd1280;
    localparam logic [DIST_W-1:0]  RST_SWITCH_FAST   = 16'd2560;
    localparam logic [DIST_W-1:0]  RST_FINE_ZONE     = 16'd384;
    localparam logic [DIST_W-1:0]  RST_ARRIVE_FAST   = 16'd512;
    localparam logic [DIST_W-1:0]  RST_ARRIVE_NORMAL = 16'd205;
    localparam logic [SPEED_W-1:0] RST_SPEED_FAR     = 15'd768;
    localparam logic [SPEED_W-1:0] RST_SPEED_NEAR    = 15'd384;
    localparam logic [SPEED_W-1:0] RST_SPEED_FINE    = 15'd128;

endpackage

// ===== sv/pspc_div_pipe.sv =====
// pspc_div_pipe: unsigned restoring divider, one quotient bit per stage,
// fully pipelined with a sideband word. Depends on nothing.
module pspc_div_pipe #(
    parameter int unsigned NW = 31,
    parameter int unsigned DW = 16,
    parameter int unsigned SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic          out_valid,
    output logic [NW-1:0] quo,
    output logic [SW-1:0] out_side
);

    logic [DW-1:0] rem_reg  [0:NW-1];
    logic [NW-1:0] num_reg  [0:NW-1];
    logic [NW-1:0] quo_reg  [0:NW-1];
    logic [DW-1:0] den_reg  [0:NW-1];
    logic [SW-1:0] side_reg [0:NW-1];
    logic [NW-1:0] vld_reg;

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [NW-1:0] num_in;
            logic [NW-1:0] quo_in;
            logic [DW-1:0] den_in;
            logic [SW-1:0] side_in;
            logic          vld_in;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 0) begin : g_first
                assign rem_in  = '0;
                assign num_in  = num;
                assign quo_in  = '0;
                assign den_in  = den;
                assign side_in = side;
                assign vld_in  = in_valid;
            end else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign num_in  = num_reg[k-1];
                assign quo_in  = quo_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign side_in = side_reg[k-1];
                assign vld_in  = vld_reg[k-1];
            end

            assign trial = {rem_in, num_in[NW-1]};
            assign ge    = trial >= {1'b0, den_in};
            assign diff  = trial - {1'b0, den_in};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    num_reg[k]  <= {num_in[NW-2:0], 1'b0};
                    quo_reg[k]  <= {quo_in[NW-2:0], ge};
                    den_reg[k]  <= den_in;
                    side_reg[k] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NW-1];
    assign quo       = quo_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

// ===== sv/piecewise_speed_profile_core.sv =====
// piecewise_speed_profile_core: zone speed selection and velocity vector.
// Depends on pspc_pkg and pspc_div_pipe.
//
//  channel   direction  handshake                 payload
//  sample    in         sample_valid/sample_stall sample_t  (offset, range, flags)
//  command   out        command_valid/command_stall command_t (vel_x, vel_y)
//  config    in         wr_en                     wr_index, wr_data
//
// One sample enters every cycle while sample_stall is low; two 31-stage
// bit-per-stage dividers compute the speed blend, then velocity over range.
// The whole pipe advances together; it holds when the command register is
// full and stalled, so nothing is lost or repeated.
// Reset clears valid bits and loads register reset values. A sample with
// zero range is taken but produces no command.
module piecewise_speed_profile_core
    import pspc_pkg::*;
#(
    parameter int unsigned LOCK_MULT = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_t              sample,
    output logic                 command_valid,
    input  logic                 command_stall,
    output command_t             command,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DIST_W-1:0]    wr_data
);

    // width of a distance after the lock scaling
    localparam int unsigned SCALE_W = $clog2(65535 * LOCK_MULT + 1);
    localparam int unsigned SIDE1_W = SPEED_W + 1 + 3 * DIST_W;

    // ---------------- configuration registers ----------------
    logic [DIST_W-1:0]  sw_normal_reg, sw_fast_reg, zone_reg;
    logic [DIST_W-1:0]  arr_fast_reg, arr_normal_reg;
    logic [SPEED_W-1:0] sp_far_reg, sp_near_reg, sp_fine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_normal_reg  <= RST_SWITCH_NORMAL;
            sw_fast_reg    <= RST_SWITCH_FAST;
            zone_reg       <= RST_FINE_ZONE;
            arr_fast_reg   <= RST_ARRIVE_FAST;
            arr_normal_reg <= RST_ARRIVE_NORMAL;
            sp_far_reg     <= RST_SPEED_FAR;
            sp_near_reg    <= RST_SPEED_NEAR;
            sp_fine_reg    <= RST_SPEED_FINE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SWITCH_NORMAL: sw_normal_reg  <= wr_data;
                REG_SWITCH_FAST:   sw_fast_reg    <= wr_data;
                REG_FINE_ZONE:     zone_reg       <= wr_data;
                REG_ARRIVE_FAST:   arr_fast_reg   <= wr_data;
                REG_ARRIVE_NORMAL: arr_normal_reg <= wr_data;
                REG_SPEED_FAR:     sp_far_reg     <= wr_data[SPEED_W-1:0];
                REG_SPEED_NEAR:    sp_near_reg    <= wr_data[SPEED_W-1:0];
                REG_SPEED_FINE:    sp_fine_reg    <= wr_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: move unless the output holds a stalled command
    logic adv;
    assign adv          = !command_valid || !command_stall;
    assign sample_stall = !adv;

    // ---------------- stage A: capture sample ----------------
    sample_t a_reg;
    logic    a_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            // zero range is consumed here and dropped
            a_vld_reg <= sample_valid && (sample.range_len != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= sample;
        end
    end

    // ---------------- stage B: zone select ----------------
    // speed = base +/- (ma * mb) / den
    logic [DIST_W-1:0]  sw_sel, arr_sel;
    logic [SCALE_W-1:0] s_lim, z_lim, d_ext, a_ext;
    logic [SPEED_W-1:0] base_c, ma_c;
    logic [DIST_W-1:0]  mb_c;
    logic [SCALE_W-1:0] den_c;
    logic               neg_c;

    always_comb
    begin
        sw_sel  = a_reg.fast_point ? sw_fast_reg : sw_normal_reg;
        arr_sel = a_reg.fast_point ? arr_fast_reg : arr_normal_reg;
        s_lim   = SCALE_W'(sw_sel);
        z_lim   = SCALE_W'(zone_reg);
        if (a_reg.aim_locked)
        begin
            s_lim = SCALE_W'(sw_sel) * SCALE_W'(LOCK_MULT);
            z_lim = SCALE_W'(zone_reg) * SCALE_W'(LOCK_MULT);
        end
        d_ext  = SCALE_W'(a_reg.range_len);
        a_ext  = SCALE_W'(arr_sel);
        base_c = '0;
        ma_c   = '0;
        mb_c   = '0;
        den_c  = SCALE_W'(1);
        neg_c  = 1'b0;
        if (d_ext > s_lim)
        begin
            base_c = sp_far_reg;
        end
        else if (d_ext > z_lim)
        begin
            base_c = sp_near_reg;
        end
        else if (d_ext > a_ext)
        begin
            // blend zone, fine speed at A up to near speed at Z
            base_c = sp_fine_reg;
            neg_c  = sp_near_reg < sp_fine_reg;
            ma_c   = neg_c ? (sp_fine_reg - sp_near_reg) : (sp_near_reg - sp_fine_reg);
            mb_c   = a_reg.range_len - arr_sel;
            den_c  = z_lim - a_ext;
        end
        else
        begin
            // inside arrival threshold; range >= 1 so A >= 1
            ma_c  = sp_fine_reg;
            mb_c  = a_reg.range_len;
            den_c = a_ext;
        end
    end

    logic [SPEED_W-1:0] b_base_reg, b_ma_reg;
    logic [DIST_W-1:0]  b_mb_reg;
    logic [SCALE_W-1:0] b_den_reg;
    logic               b_neg_reg, b_vld_reg;
    logic signed [15:0] b_dx_reg, b_dy_reg;
    logic [DIST_W-1:0]  b_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_base_reg <= base_c;
            b_ma_reg   <= ma_c;
            b_mb_reg   <= mb_c;
            b_den_reg  <= den_c;
            b_neg_reg  <= neg_c;
            b_dx_reg   <= a_reg.offset_x;
            b_dy_reg   <= a_reg.offset_y;
            b_d_reg    <= a_reg.range_len;
        end
    end

    // ---------------- stage C: blend product ----------------
    logic [PROD_W-1:0]  c_num_reg;
    logic [SCALE_W-1:0] c_den_reg;
    logic [SIDE1_W-1:0] c_side_reg;
    logic               c_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_num_reg  <= PROD_W'(b_ma_reg) * PROD_W'(b_mb_reg);
            c_den_reg  <= b_den_reg;
            c_side_reg <= {b_base_reg, b_neg_reg, b_dx_reg, b_dy_reg, b_d_reg};
        end
    end

    // ---------------- speed divider ----------------
    logic               q1_vld;
    logic [PROD_W-1:0]  q1;
    logic [SIDE1_W-1:0] q1_side;

    pspc_div_pipe #(
        .NW (PROD_W),
        .DW (SCALE_W),
        .SW (SIDE1_W)
    ) u_div_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_vld_reg),
        .num       (c_num_reg),
        .den       (c_den_reg),
        .side      (c_side_reg),
        .out_valid (q1_vld),
        .quo       (q1),
        .out_side  (q1_side)
    );

    // ---------------- stage D: final speed, offset magnitudes ----------------
    logic [SPEED_W-1:0] q1_base;
    logic               q1_neg;
    logic signed [15:0] q1_dx, q1_dy;
    logic [DIST_W-1:0]  q1_d;

    assign {q1_base, q1_neg, q1_dx, q1_dy, q1_d} = q1_side;

    logic [SPEED_W-1:0] d_speed_reg;
    logic [15:0]        d_ax_reg, d_ay_reg;
    logic               d_sx_reg, d_sy_reg, d_vld_reg;
    logic [DIST_W-1:0]  d_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= q1_vld;
        end
    end

    // blend quotient never exceeds the speed span, so 15 bits hold it
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_speed_reg <= q1_neg ? (q1_base - q1[SPEED_W-1:0])
                                  : (q1_base + q1[SPEED_W-1:0]);
            d_sx_reg    <= q1_dx[15];
            d_sy_reg    <= q1_dy[15];
            d_ax_reg    <= q1_dx[15] ? (16'd0 - q1_dx) : q1_dx;
            d_ay_reg    <= q1_dy[15] ? (16'd0 - q1_dy) : q1_dy;
            d_d_reg     <= q1_d;
        end
    end

    // ---------------- stage E: velocity products ----------------
    logic [PROD_W-1:0] e_px_reg, e_py_reg;
    logic [DIST_W-1:0] e_d_reg;
    logic              e_sx_reg, e_sy_reg, e_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_px_reg <= PROD_W'(d_ax_reg) * PROD_W'(d_speed_reg);
            e_py_reg <= PROD_W'(d_ay_reg) * PROD_W'(d_speed_reg);
            e_d_reg  <= d_d_reg;
            e_sx_reg <= d_sx_reg;
            e_sy_reg <= d_sy_reg;
        end
    end

    // ---------------- velocity dividers ----------------
    logic              qx_vld, qy_vld, qx_s, qy_s;
    logic [PROD_W-1:0] qx, qy;

    pspc_div_pipe #(
        .NW (PROD_W),
        .DW (DIST_W),
        .SW (1)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (e_vld_reg),
        .num       (e_px_reg),
        .den       (e_d_reg),
        .side      (e_sx_reg),
        .out_valid (qx_vld),
        .quo       (qx),
        .out_side  (qx_s)
    );

    pspc_div_pipe #(
        .NW (PROD_W),
        .DW (DIST_W),
        .SW (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (e_vld_reg),
        .num       (e_py_reg),
        .den       (e_d_reg),
        .side      (e_sy_reg),
        .out_valid (qy_vld),
        .quo       (qy),
        .out_side  (qy_s)
    );

    // ---------------- output: sign and saturate ----------------
    function automatic logic signed [15:0] sat_signed(input logic neg,
                                                      input logic [PROD_W-1:0] mag);
        logic signed [15:0] r;
        if (!neg)
        begin
            r = (mag > PROD_W'(32767)) ? 16'sd32767 : 16'(mag);
        end
        else
        begin
            r = (mag > PROD_W'(32768)) ? -16'sd32768 : 16'(16'd0 - mag[15:0]);
        end
        return r;
    endfunction

    command_t cmd_reg;
    logic     cmd_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            cmd_vld_reg <= qx_vld && qy_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_reg.vel_x <= sat_signed(qx_s, qx);
            cmd_reg.vel_y <= sat_signed(qy_s, qy);
        end
    end

    assign command_valid = cmd_vld_reg;
    assign command       = cmd_reg;

endmodule
